/* rtl/feff_pkg.sv */
// shared types and codes for the first-fit free extent finder
package feff_pkg;

  localparam int MAX_EXTENTS_DEF = 128;
  localparam int SECTOR_BITS_DEF = 32;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_FIND  = 2'd2;
  localparam logic [1:0] CMD_CHECK = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OVERLAP = 3'd1;
  localparam logic [2:0] ST_TOO_BIG = 3'd2;
  localparam logic [2:0] ST_NO_GAP  = 3'd3;
  localparam logic [2:0] ST_SMALL   = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  // config register indexes
  localparam logic REG_FIRST_USABLE = 1'b0;
  localparam logic REG_LAST_USABLE  = 1'b1;

  typedef struct packed {
    logic accept;     // latch the input beat and set up the walk
    logic clr_cnt;    // empty the table
    logic emit_ok;    // give an ok result
    logic emit_full;  // give a full result
    logic ins_rd;     // read entry idx-1
    logic ins_shift;  // move entry idx-1 up to idx
    logic ins_new;    // write the new extent at idx
    logic walk_rd;    // read entry idx
    logic walk_step;  // process one extent of the walk
    logic walk_fin;   // close the walk and give its result
  } ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic idx_one;
    logic rd_greater;
    logic walk_last;
  } sts_t;

endpackage

/* rtl/feff_ctrl.sv */
// controller state machine for the first-fit free extent finder
module feff_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    command_i,
  input  feff_pkg::sts_t sts_i,
  output feff_pkg::ctl_t ctl_o
);
  import feff_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_INS_NEW  = 3'd3;
  localparam logic [2:0] S_WALK_RD  = 3'd4;
  localparam logic [2:0] S_WALK     = 3'd5;
  localparam logic [2:0] S_WALK_FIN = 3'd6;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          case (command_i)
            CMD_CLEAR: begin
              ctl_o.clr_cnt = 1'b1;
              ctl_o.emit_ok = 1'b1;
            end
            CMD_ADD: begin
              if (sts_i.full) begin
                ctl_o.emit_full = 1'b1;
              end else if (sts_i.cnt_zero) begin
                state_d = S_INS_NEW;
              end else begin
                state_d = S_INS_RD;
              end
            end
            default: begin
              state_d = sts_i.cnt_zero ? S_WALK_FIN : S_WALK_RD;
            end
          endcase
        end
      end
      S_INS_RD: begin
        ctl_o.ins_rd = 1'b1;
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (sts_i.rd_greater) begin
          ctl_o.ins_shift = 1'b1;
          if (sts_i.idx_one) state_d = S_INS_NEW;
        end else begin
          ctl_o.ins_new = 1'b1;
          ctl_o.emit_ok = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_INS_NEW: begin
        ctl_o.ins_new = 1'b1;
        ctl_o.emit_ok = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK_RD: begin
        ctl_o.walk_rd = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        ctl_o.walk_step = 1'b1;
        if (sts_i.walk_last) state_d = S_WALK_FIN;
      end
      S_WALK_FIN: begin
        ctl_o.walk_fin = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/feff_dpath.sv */
// extent table memory, walk logic and result registers
module feff_dpath #(
  parameter int MAX_EXTENTS = feff_pkg::MAX_EXTENTS_DEF,
  parameter int SECTOR_BITS = feff_pkg::SECTOR_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  feff_pkg::ctl_t ctl_i,
  output feff_pkg::sts_t sts_o,
  input  logic [1:0]     command_i,
  input  logic [31:0]    extent_first_i,
  input  logic [31:0]    extent_last_i,
  input  logic [31:0]    request_start_i,
  input  logic [31:0]    request_size_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i,
  output logic           done_o,
  output logic [2:0]     status_o,
  output logic [31:0]    found_start_o
);
  import feff_pkg::*;

  localparam int SW = SECTOR_BITS;
  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int NW = (SECTOR_BITS < 32) ? SECTOR_BITS : 32;
  localparam int XW = (SECTOR_BITS > 32) ? SECTOR_BITS : 32;

  function automatic logic [SW-1:0] to_sect(input logic [31:0] v);
    logic [SW-1:0] s;
    s = '0;
    s[NW-1:0] = v[NW-1:0];
    return s;
  endfunction

  function automatic logic [31:0] to_w32(input logic [SW-1:0] s);
    logic [31:0] v;
    v = '0;
    v[NW-1:0] = s[NW-1:0];
    return v;
  endfunction

  logic [2*SW-1:0] mem [MAX_EXTENTS];
  logic [2*SW-1:0] rd_q;

  logic [1:0]    cmd_q;
  logic [SW-1:0] ef_q, el_q, addr_q;
  logic [31:0]   want_q;
  logic [SW-1:0] fu_q, lu_q;
  logic [CW-1:0] cnt_q, idx_q;

  logic [SW-1:0] nxt_q;
  logic          over_q, ovl_q, hit_q;
  logic [SW-1:0] hit_start_q;
  logic [2:0]    hit_st_q;

  logic          done_q;
  logic [2:0]    status_q;
  logic [31:0]   found_q;

  logic [SW-1:0] base, top;
  assign base = rd_q[2*SW-1:SW];
  assign top  = rd_q[SW-1:0];

  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.full       = (cnt_q == CW'(MAX_EXTENTS));
  assign sts_o.idx_one    = (idx_q == CW'(1));
  assign sts_o.rd_greater = (base > ef_q);
  assign sts_o.walk_last  = (idx_q == cnt_q - CW'(1));

  // memory addressing
  logic [CW-1:0]   raddr_c;
  logic            re;
  logic            we;
  logic [2*SW-1:0] wdata;

  always_comb begin
    if (ctl_i.ins_rd)         raddr_c = idx_q - CW'(1);
    else if (ctl_i.ins_shift) raddr_c = idx_q - CW'(2);
    else if (ctl_i.walk_step) raddr_c = idx_q + CW'(1);
    else                      raddr_c = idx_q;
  end

  // read only when the sequencer asks for an entry
  assign re    = ctl_i.ins_rd | ctl_i.ins_shift | ctl_i.walk_rd | ctl_i.walk_step;
  assign we    = ctl_i.ins_shift | ctl_i.ins_new;
  assign wdata = ctl_i.ins_shift ? rd_q : {ef_q, el_q};

  always_ff @(posedge clk_i) begin
    if (we) mem[idx_q[AW-1:0]] <= wdata;
    if (re) rd_q <= mem[raddr_c[AW-1:0]];
  end

  // gap visit, shared by the per-extent step and the closing gap
  logic          find;
  logic          step_ovl, end_over, too_big, vis_en, in_gap, room, v_hit;
  logic [SW:0]   lu_p1;
  logic [SW-1:0] ge, from, diff, v_start;
  logic [2:0]    v_st;

  always_comb begin
    find     = (cmd_q == CMD_FIND);
    step_ovl = over_q | (base < nxt_q);
    end_over = &lu_q;
    lu_p1    = {1'b0, lu_q} + (SW+1)'(1);
    too_big  = over_q ? !end_over : (!end_over && ({1'b0, nxt_q} > lu_p1));
    if (ctl_i.walk_step) begin
      vis_en = !step_ovl && (base > nxt_q);
      ge     = base - SW'(1);
    end else begin
      vis_en = !over_q && !too_big && (nxt_q <= lu_q);
      ge     = lu_q;
    end
    vis_en  = vis_en && !hit_q;
    from    = find ? nxt_q : addr_q;
    diff    = ge - from;
    room    = (want_q == '0) || (XW'(diff) >= (XW'(want_q) - XW'(1)));
    in_gap  = (addr_q >= nxt_q) && (addr_q <= ge);
    v_hit   = vis_en && (find ? room : in_gap);
    v_start = find ? nxt_q : '0;
    v_st    = (find || room) ? ST_OK : ST_SMALL;
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q       <= command_i;
      ef_q        <= to_sect(extent_first_i);
      el_q        <= to_sect(extent_last_i);
      addr_q      <= to_sect(request_start_i);
      want_q      <= request_size_i;
      idx_q       <= (command_i == CMD_ADD) ? cnt_q : '0;
      nxt_q       <= fu_q;
      over_q      <= 1'b0;
      ovl_q       <= 1'b0;
      hit_q       <= 1'b0;
      hit_start_q <= '0;
      hit_st_q    <= ST_NO_GAP;
    end
    if (ctl_i.ins_shift) idx_q <= idx_q - CW'(1);
    if (ctl_i.walk_step) begin
      idx_q  <= idx_q + CW'(1);
      ovl_q  <= ovl_q | step_ovl;
      over_q <= &top;
      nxt_q  <= top + SW'(1);
      if (v_hit) begin
        hit_q       <= 1'b1;
        hit_start_q <= v_start;
        hit_st_q    <= v_st;
      end
    end
    if (ctl_i.emit_ok) begin
      status_q <= ST_OK;
      found_q  <= '0;
    end else if (ctl_i.emit_full) begin
      status_q <= ST_FULL;
      found_q  <= '0;
    end else if (ctl_i.walk_fin) begin
      if (ovl_q) begin
        status_q <= ST_OVERLAP;
        found_q  <= '0;
      end else if (too_big) begin
        status_q <= ST_TOO_BIG;
        found_q  <= '0;
      end else if (hit_q) begin
        status_q <= hit_st_q;
        found_q  <= to_w32(hit_start_q);
      end else if (v_hit) begin
        status_q <= v_st;
        found_q  <= to_w32(v_start);
      end else begin
        status_q <= ST_NO_GAP;
        found_q  <= '0;
      end
    end
  end

  // control and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      fu_q   <= to_sect(32'd34);
      lu_q   <= to_sect(32'hFFFF_FFFF);
    end else begin
      done_q <= ctl_i.emit_ok | ctl_i.emit_full | ctl_i.walk_fin;
      if (ctl_i.clr_cnt)      cnt_q <= '0;
      else if (ctl_i.ins_new) cnt_q <= cnt_q + CW'(1);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIRST_USABLE: fu_q <= to_sect(cfg_wdata_i);
          REG_LAST_USABLE:  lu_q <= to_sect(cfg_wdata_i);
          default:          fu_q <= fu_q;
        endcase
      end
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_start_o = found_q;

endmodule

/* rtl/free_extent_first_fit_finder.sv */
// first-fit free extent finder: sorted extent table with gap search
// clear and a full add give their result in the cycle after the beat;
//   add shifts one stored extent per cycle until it reaches the insert slot,
//   find and check walk the table one extent per cycle
// throughput: one beat at a time, start is taken only while busy is low
// reset: asynchronous, empties the table and restores the usable range; the receiver
//   cannot stall, each result is shown on done_o for a single cycle
module free_extent_first_fit_finder #(
  parameter int MAX_EXTENTS = feff_pkg::MAX_EXTENTS_DEF,
  parameter int SECTOR_BITS = feff_pkg::SECTOR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] extent_first_i,
  input  logic [31:0] extent_last_i,
  input  logic [31:0] request_start_i,
  input  logic [31:0] request_size_i,
  // config writes, only while idle
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // result beat
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] found_start_o
);
  import feff_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer: insert walks down from the top shifting larger entries up,
  // find and check walk up from the bottom tracking the next free sector
  feff_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  // table memory, gap compare and result registers
  feff_dpath #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .command_i       (command_i),
    .extent_first_i  (extent_first_i),
    .extent_last_i   (extent_last_i),
    .request_start_i (request_start_i),
    .request_size_i  (request_size_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_start_o   (found_start_o)
  );

endmodule

/* sim/tb.sv */
// testbench for the first-fit free extent finder: random and directed command beats
`timescale 1ns / 1ps
module tb;
  import feff_pkg::*;

  localparam int NUM_SLOTS = 128;
  localparam int RAND_BEATS = 1740;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  // one command beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] ext_first;
    logic [31:0] ext_last;
    logic [31:0] req_start;
    logic [31:0] req_size;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] start_sec;
  } answer_t;

  typedef logic bool_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = CMD_CLEAR;
  logic [31:0] extent_first_i = '0;
  logic [31:0] extent_last_i = '0;
  logic [31:0] request_start_i = '0;
  logic [31:0] request_size_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_FIRST_USABLE;
  logic [31:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] found_start_o;

  free_extent_first_fit_finder u_top (
    .clk_i, .rst_ni, .start, .busy,
    .command_i, .extent_first_i, .extent_last_i, .request_start_i, .request_size_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .done_o, .status_o, .found_start_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the extent table and usable range
  logic [31:0] tbl_first[NUM_SLOTS];
  logic [31:0] tbl_last[NUM_SLOTS];
  int          tbl_count = 0;
  logic [31:0] usable_lo;
  logic [31:0] usable_hi;

  beat_t   pending_beats[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      answers_seen = 0;
  int      n_ok = 0, n_overlap = 0, n_too_big = 0, n_no_gap = 0, n_small = 0, n_full = 0;
  longint  cycle_count = 0;
  bool_t   no_idle;

  // gap walk for find and check, 33-bit sums keep it exact
  function automatic answer_t gap_walk(beat_t b);
    answer_t  r;
    logic [32:0] nxt;
    logic     over, overlap, too_big, hit, end_over;
    logic [2:0]  hit_st;
    logic [31:0] hit_sec;
    logic [32:0] gs, ge;
    r = '0;
    nxt = {1'b0, usable_lo};
    over = 1'b0;
    overlap = 1'b0;
    hit = 1'b0;
    hit_st = ST_NO_GAP;
    hit_sec = '0;
    end_over = (usable_hi == 32'hFFFF_FFFF);
    for (int i = 0; i <= tbl_count; i++) begin
      if (i < tbl_count) begin
        if (over || {1'b0, tbl_first[i]} < nxt) begin
          overlap = 1'b1;
          gs = '0; ge = '0;
        end else begin
          gs = nxt;
          ge = {1'b0, tbl_first[i]} - 33'd1;
        end
        if (!(over || {1'b0, tbl_first[i]} <= nxt) && !hit) begin
          if (b.cmd == CMD_FIND) begin
            if (b.req_size == 0 || ge - gs >= {1'b0, b.req_size} - 33'd1) begin
              hit = 1'b1; hit_st = ST_OK; hit_sec = gs[31:0];
            end
          end else if ({1'b0, b.req_start} >= gs && {1'b0, b.req_start} <= ge) begin
            hit = 1'b1;
            hit_st = (b.req_size == 0 || ge - b.req_start >= {1'b0, b.req_size} - 33'd1)
                     ? ST_OK : ST_SMALL;
          end
        end
        over = (tbl_last[i] == 32'hFFFF_FFFF);
        nxt = {1'b0, tbl_last[i] + 32'd1};
      end
    end
    too_big = over ? !end_over : (!end_over && nxt > {1'b0, usable_hi} + 33'd1);
    if (!over && !too_big && nxt <= {1'b0, usable_hi} && !hit) begin
      gs = nxt;
      ge = {1'b0, usable_hi};
      if (b.cmd == CMD_FIND) begin
        if (b.req_size == 0 || ge - gs >= {1'b0, b.req_size} - 33'd1) begin
          hit = 1'b1; hit_st = ST_OK; hit_sec = gs[31:0];
        end
      end else if ({1'b0, b.req_start} >= gs && {1'b0, b.req_start} <= ge) begin
        hit = 1'b1;
        hit_st = (b.req_size == 0 || ge - b.req_start >= {1'b0, b.req_size} - 33'd1)
                 ? ST_OK : ST_SMALL;
      end
    end
    if (overlap) r.status = ST_OVERLAP;
    else if (too_big) r.status = ST_TOO_BIG;
    else if (!hit) r.status = ST_NO_GAP;
    else begin
      r.status = hit_st;
      r.start_sec = hit_sec;
    end
    return r;
  endfunction

  // applies one accepted beat to the shadow table and gives its answer
  function automatic answer_t predict_answer(beat_t b);
    answer_t r;
    int pos;
    r = '0;
    case (b.cmd)
      CMD_CLEAR: tbl_count = 0;
      CMD_ADD: begin
        if (tbl_count >= NUM_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_first[pos] <= b.ext_first) pos++;
          for (int j = tbl_count; j > pos; j--) begin
            tbl_first[j] = tbl_first[j-1];
            tbl_last[j] = tbl_last[j-1];
          end
          tbl_first[pos] = b.ext_first;
          tbl_last[pos] = b.ext_last;
          tbl_count++;
        end
      end
      default: r = gap_walk(b);
    endcase
    return r;
  endfunction

  // set at the rising edge that took a beat
  logic beat_taken = 1'b0;

  // driver: one beat per handshake, random idle bursts unless no_idle
  int idle_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (beat_taken && !no_idle && $urandom_range(0, 7) == 0)
        idle_left = $urandom_range(1, 19);
      // a waiting beat stays on the ports until it is taken
      if (!start || beat_taken) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          start <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          command_i <= pending_beats[0].cmd;
          extent_first_i <= pending_beats[0].ext_first;
          extent_last_i <= pending_beats[0].ext_last;
          request_start_i <= pending_beats[0].req_start;
          request_size_i <= pending_beats[0].req_size;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // acceptance and result check at the rising edge
  always @(posedge clk_i) begin
    beat_t b;
    answer_t want;
    logic taken;
    taken = rst_ni && start && !busy;
    cycle_count <= cycle_count + 1;
    beat_taken <= taken;
    if (taken) begin
      b = pending_beats.pop_front();
      expected_answers.push_back(predict_answer(b));
    end
    if (rst_ni && done_o) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", status_o);
      end else begin
        want = expected_answers.pop_front();
        case (want.status)
          ST_OK: n_ok++;
          ST_OVERLAP: n_overlap++;
          ST_TOO_BIG: n_too_big++;
          ST_NO_GAP: n_no_gap++;
          ST_SMALL: n_small++;
          default: n_full++;
        endcase
        if (status_o !== want.status || found_start_o !== want.start_sec) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, start exp %h got %h",
                     want.status, status_o, want.start_sec, found_start_o);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // random sector near a small window so extents collide and leave gaps
  function automatic logic [31:0] rand_sector();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      1: return $urandom();
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  function automatic beat_t rand_beat(logic [1:0] cmd);
    beat_t b;
    b.cmd = cmd;
    b.ext_first = rand_sector();
    b.ext_last = ($urandom_range(0, 15) == 0) ? rand_sector()
                 : b.ext_first + $urandom_range(0, 30);
    b.req_start = rand_sector();
    case ($urandom_range(0, 5))
      0: b.req_size = 0;
      1: b.req_size = $urandom();
      default: b.req_size = $urandom_range(1, 80);
    endcase
    return b;
  endfunction

  // waits until every beat has been taken and answered, then lets the walk settle
  task automatic drain();
    while (pending_beats.size() != 0 || expected_answers.size() != 0) @(posedge clk_i);
    repeat (NUM_SLOTS + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FIRST_USABLE) usable_lo = val;
    else usable_hi = val;
  endtask

  task automatic push(logic [1:0] cmd, logic [31:0] f, logic [31:0] l,
                      logic [31:0] s, logic [31:0] z);
    beat_t b;
    b = '{cmd, f, l, s, z};
    pending_beats.push_back(b);
  endtask

  initial begin
    beat_t b;
    logic [1:0] cmd;
    int sel;
    usable_lo = 32'd34;
    usable_hi = 32'hFFFF_FFFF;
    no_idle = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: reset range, empty table, extremes, overlap, reversed, oversize
    push(CMD_FIND, 0, 0, 0, 0);
    push(CMD_CHECK, 0, 0, 34, 32'hFFFF_FFFF);
    push(CMD_CHECK, 0, 0, 33, 1);
    push(CMD_FIND, 0, 0, 0, 32'hFFFF_FFCC);
    push(CMD_FIND, 0, 0, 0, 32'hFFFF_FFCD);
    push(CMD_ADD, 100, 199, 0, 0);
    push(CMD_ADD, 40, 59, 0, 0);
    push(CMD_FIND, 0, 0, 0, 6);
    push(CMD_FIND, 0, 0, 0, 7);
    push(CMD_CHECK, 0, 0, 60, 40);
    push(CMD_CHECK, 0, 0, 60, 41);
    push(CMD_CHECK, 0, 0, 150, 1);
    push(CMD_ADD, 150, 160, 0, 0);
    push(CMD_FIND, 0, 0, 0, 1);
    push(CMD_CLEAR, 0, 0, 0, 0);
    push(CMD_ADD, 300, 250, 0, 0);
    push(CMD_FIND, 0, 0, 0, 5);
    push(CMD_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0, 0);
    push(CMD_FIND, 0, 0, 0, 32'hFFFF_FFFF);
    push(CMD_CHECK, 0, 0, 32'hFFFF_FFFF, 0);
    push(CMD_CLEAR, 0, 0, 0, 0);
    push(CMD_ADD, 0, 10, 0, 0);
    push(CMD_FIND, 0, 0, 0, 0);
    push(CMD_CLEAR, 0, 0, 0, 0);
    drain();

    write_reg(REG_FIRST_USABLE, 32'd0);
    write_reg(REG_LAST_USABLE, 32'd1000);
    push(CMD_ADD, 990, 1001, 0, 0);
    push(CMD_FIND, 0, 0, 0, 3);
    push(CMD_CLEAR, 0, 0, 0, 0);
    push(CMD_ADD, 995, 1000, 0, 0);
    push(CMD_CHECK, 0, 0, 0, 995);
    push(CMD_CHECK, 0, 0, 0, 996);
    drain();

    // empty usable range
    write_reg(REG_FIRST_USABLE, 32'hFFFF_FFFF);
    write_reg(REG_LAST_USABLE, 32'h0);
    push(CMD_CLEAR, 0, 0, 0, 0);
    push(CMD_FIND, 0, 0, 0, 0);
    drain();
    write_reg(REG_FIRST_USABLE, 32'd5);
    write_reg(REG_LAST_USABLE, 32'd3);
    push(CMD_FIND, 0, 0, 0, 0);
    drain();

    // fill to capacity, then overflow
    write_reg(REG_FIRST_USABLE, 32'd34);
    write_reg(REG_LAST_USABLE, 32'hFFFF_FFFF);
    for (int i = 0; i < NUM_SLOTS + 2; i++)
      push(CMD_ADD, 32'd40 + (32'(NUM_SLOTS - i) * 8), 32'd42 + (32'(NUM_SLOTS - i) * 8), 0, 0);
    push(CMD_FIND, 0, 0, 0, 5);
    push(CMD_FIND, 0, 0, 0, 6);
    push(CMD_CHECK, 0, 0, 43, 5);
    drain();

    // random phases, each with its own usable range and random beats, cleared every 40 beats
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_FIRST_USABLE, 0); write_reg(REG_LAST_USABLE, 32'hFFFF_FFFF); end
        1: begin write_reg(REG_FIRST_USABLE, 34); write_reg(REG_LAST_USABLE, 700); end
        2: begin write_reg(REG_FIRST_USABLE, $urandom_range(0, 300));
                 write_reg(REG_LAST_USABLE, $urandom_range(300, 800)); end
        3: begin write_reg(REG_FIRST_USABLE, 32'hFFFF_FFFF);
                 write_reg(REG_LAST_USABLE, 32'hFFFF_FFFF); end
        default: begin write_reg(REG_FIRST_USABLE, $urandom_range(0, 100));
                 write_reg(REG_LAST_USABLE, ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                             : $urandom_range(400, 700)); end
      endcase
      if (ph == 7) no_idle = 1'b1;
      for (int k = 0; k < RAND_BEATS / 8; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 3) cmd = CMD_CLEAR;
        else if (sel < 40) cmd = CMD_ADD;
        else if (sel < 70) cmd = CMD_FIND;
        else cmd = CMD_CHECK;
        b = rand_beat(cmd);
        // build sparse non-overlapping tables most of the time
        if (cmd == CMD_ADD && $urandom_range(0, 3) != 0) begin
          b.ext_first = 32'($urandom_range(0, 60)) * 12 + 34;
          b.ext_last = b.ext_first + $urandom_range(0, 6);
        end
        pending_beats.push_back(b);
        if (k % 40 == 39) push(CMD_CLEAR, 0, 0, 0, 0);
      end
      drain();
    end

    $display("covered %0d result beats: ok %0d, overlap %0d, too big %0d, no gap %0d,",
             answers_seen, n_ok, n_overlap, n_too_big, n_no_gap);
    $display("  too little space %0d, full %0d, with range registers at both extremes",
             n_small, n_full);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
